### rtl/core/lmfs_pkg.sv
package lmfs_pkg;

    localparam int DEF_PANEL_COLUMNS = 32;
    localparam int DEF_PANEL_ROWS    = 16;

    localparam int OP_W       = 2;
    localparam int START_ROW_W = 4;
    localparam int START_COL_W = 5;
    localparam int RECT_W_W   = 6;
    localparam int RECT_H_W   = 5;
    localparam int ROW_ADDR_W = 3;
    localparam int COLUMN_W   = 5;
    localparam int COLOR_W    = 3;

    // wide enough for start + extent at the largest panel
    localparam int ROW_SUM_W  = 8;
    localparam int COL_SUM_W  = 9;

    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

    typedef struct packed {
        logic we_top;
        logic we_bot;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic [ROW_ADDR_W-1:0] row_address;
        logic [COLUMN_W-1:0]   column_index;
        logic                  latch_last;
    } t_scan_tag;

    typedef struct packed {
        t_scan_tag          tag;
        logic [COLOR_W-1:0] top;
        logic [COLOR_W-1:0] bot;
    } t_out_word;

endpackage

### rtl/core/lmfs_if.sv
interface lmfs_cmd_if;
    import lmfs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [START_ROW_W-1:0] start_row;
    logic [START_COL_W-1:0] start_col;
    logic [RECT_W_W-1:0]    rect_width;
    logic [RECT_H_W-1:0]    rect_height;
    logic                   color_red;
    logic                   color_green;
    logic                   color_blue;

    modport source (
        output valid, operation, start_row, start_col, rect_width, rect_height,
               color_red, color_green, color_blue,
        input  ready
    );
    modport sink (
        input  valid, operation, start_row, start_col, rect_width, rect_height,
               color_red, color_green, color_blue,
        output ready
    );
endinterface

interface lmfs_pix_if;
    import lmfs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [COLUMN_W-1:0]   column_index;
    logic                  top_red;
    logic                  top_green;
    logic                  top_blue;
    logic                  bottom_red;
    logic                  bottom_green;
    logic                  bottom_blue;
    logic                  latch_last;

    modport source (
        output valid, row_address, column_index, top_red, top_green, top_blue,
               bottom_red, bottom_green, bottom_blue, latch_last,
        input  ready
    );
    modport sink (
        input  valid, row_address, column_index, top_red, top_green, top_blue,
               bottom_red, bottom_green, bottom_blue, latch_last,
        output ready
    );
endinterface

### rtl/core/led_matrix_framebuffer_scan.sv
// channel  | dir | carries                                  | moves when
// i_cmd    | in  | pixel write, rectangle fill, refresh tick | valid && ready
// o_pix    | out | one panel column, top and bottom RGB     | valid && ready
//
// Pixel write: written in the cycle after accept; fill: one clipped pixel written per cycle.
// Refresh: one frame store read per column, held while the output queue is full, then ready.
// Output queue of two words lets reads run one per cycle while the sink takes them.
// After reset the frame store is cleared, all (PANEL_ROWS/2)*PANEL_COLUMNS entries
// (256 by default) one address at a time, with i_cmd.ready low.
// A stalled output holds the scan; the frame store keeps its contents.
module led_matrix_framebuffer_scan #(
    parameter int PANEL_COLUMNS = lmfs_pkg::DEF_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = lmfs_pkg::DEF_PANEL_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmfs_cmd_if.sink   i_cmd,
    lmfs_pix_if.source o_pix
);
    import lmfs_pkg::*;

    localparam int DEPTH = (PANEL_ROWS / 2) * PANEL_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    t_mem_ctl           ctl;
    t_scan_tag          tag;
    logic [AW-1:0]      waddr, raddr;
    logic [COLOR_W-1:0] wdata, top_data, bot_data;
    logic               space;

    lmfs_seq #(
        .PANEL_COLUMNS(PANEL_COLUMNS),
        .PANEL_ROWS   (PANEL_ROWS)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .i_space(space),
        .o_ctl  (ctl),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_raddr(raddr),
        .o_tag  (tag)
    );

    lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_top_ram (
        .i_clk  (i_clk),
        .i_we   (ctl.we_top),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (ctl.re),
        .i_raddr(raddr),
        .o_rdata(top_data)
    );

    lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_bot_ram (
        .i_clk  (i_clk),
        .i_we   (ctl.we_bot),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (ctl.re),
        .i_raddr(raddr),
        .o_rdata(bot_data)
    );

    lmfs_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (ctl.re),
        .i_tag  (tag),
        .i_top  (top_data),
        .i_bot  (bot_data),
        .o_space(space),
        .o_pix  (o_pix)
    );
endmodule

### rtl/core/lmfs_ram.sv
module lmfs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/lmfs_seq.sv
module lmfs_seq #(
    parameter int PANEL_COLUMNS = lmfs_pkg::DEF_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = lmfs_pkg::DEF_PANEL_ROWS,
    localparam int AW = $clog2((PANEL_ROWS / 2) * PANEL_COLUMNS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lmfs_cmd_if.sink                 i_cmd,
    input  logic                     i_space,
    output lmfs_pkg::t_mem_ctl       o_ctl,
    output logic [AW-1:0]            o_waddr,
    output logic [lmfs_pkg::COLOR_W-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr,
    output lmfs_pkg::t_scan_tag      o_tag
);
    import lmfs_pkg::*;

    localparam int HALF   = PANEL_ROWS / 2;
    localparam int DEPTH  = HALF * PANEL_COLUMNS;
    localparam int ROW_W  = $clog2(PANEL_ROWS + 1);
    localparam int COL_W  = $clog2(PANEL_COLUMNS + 1);
    localparam int HROW_W = $clog2(HALF);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FILL  = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [COL_W-1:0]    r_start_col, n_start_col;
    logic [ROW_W-1:0]    r_end_row, n_end_row;
    logic [COL_W-1:0]    r_end_col, n_end_col;
    logic [COLOR_W-1:0]  r_rgb, n_rgb;
    logic [HROW_W-1:0]   r_pair, n_pair;

    logic                 acc;
    logic [RECT_H_W-1:0]  eff_h;
    logic [RECT_W_W-1:0]  eff_w;
    logic [ROW_SUM_W-1:0] row_sum, end_row;
    logic [COL_SUM_W-1:0] col_sum, end_col;
    logic                 empty;
    logic                 is_bot;
    logic [ROW_W-1:0]     hrow;
    logic [HROW_W-1:0]    drow;
    logic [AW-1:0]        fill_addr;
    logic                 scan_last;
    logic                 fill_col_last;
    logic                 fill_row_last;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign acc = i_cmd.valid && i_cmd.ready;

    always_comb begin
        eff_h = (i_cmd.operation == OP_PIXEL) ? RECT_H_W'(1) : i_cmd.rect_height;
        eff_w = (i_cmd.operation == OP_PIXEL) ? RECT_W_W'(1) : i_cmd.rect_width;
        row_sum = ROW_SUM_W'(i_cmd.start_row) + ROW_SUM_W'(eff_h);
        col_sum = COL_SUM_W'(i_cmd.start_col) + COL_SUM_W'(eff_w);
        end_row = (row_sum > ROW_SUM_W'(PANEL_ROWS)) ? ROW_SUM_W'(PANEL_ROWS) : row_sum;
        end_col = (col_sum > COL_SUM_W'(PANEL_COLUMNS)) ? COL_SUM_W'(PANEL_COLUMNS)
                                                         : col_sum;
        empty = (eff_h == '0) || (eff_w == '0)
             || (ROW_SUM_W'(i_cmd.start_row) >= ROW_SUM_W'(PANEL_ROWS))
             || (COL_SUM_W'(i_cmd.start_col) >= COL_SUM_W'(PANEL_COLUMNS));
    end

    always_comb begin
        is_bot = (r_row >= ROW_W'(HALF));
        hrow   = is_bot ? (r_row - ROW_W'(HALF)) : r_row;
        drow   = (hrow == '0) ? HROW_W'(HALF - 1) : HROW_W'(hrow - ROW_W'(1));
        fill_addr = AW'(drow) * AW'(PANEL_COLUMNS) + AW'(r_col);
    end

    assign scan_last     = (r_col == COL_W'(PANEL_COLUMNS - 1));
    assign fill_col_last = ((r_col + COL_W'(1)) == r_end_col);
    assign fill_row_last = ((r_row + ROW_W'(1)) == r_end_row);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_start_col = r_start_col;
        n_end_row   = r_end_row;
        n_end_col   = r_end_col;
        n_rgb       = r_rgb;
        n_pair      = r_pair;
        o_ctl       = '0;

        case (r_state)
            S_CLEAR: begin
                o_ctl.we_top = 1'b1;
                o_ctl.we_bot = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_cmd.operation)
                        OP_PIXEL, OP_FILL: begin
                            n_row       = ROW_W'(i_cmd.start_row);
                            n_col       = COL_W'(i_cmd.start_col);
                            n_start_col = COL_W'(i_cmd.start_col);
                            n_end_row   = ROW_W'(end_row);
                            n_end_col   = COL_W'(end_col);
                            n_rgb = {i_cmd.color_blue, i_cmd.color_green, i_cmd.color_red};
                            if (!empty) begin
                                n_state = S_FILL;
                            end
                        end
                        OP_REFRESH: begin
                            n_col   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_ctl.we_top = !is_bot;
                o_ctl.we_bot = is_bot;
                if (fill_col_last) begin
                    n_col = r_start_col;
                    n_row = r_row + ROW_W'(1);
                    if (fill_row_last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_SCAN: begin
                if (i_space) begin
                    o_ctl.re = 1'b1;
                    n_col = r_col + COL_W'(1);
                    if (scan_last) begin
                        n_pair  = (r_pair == HROW_W'(HALF - 1)) ? '0 : r_pair + HROW_W'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pair  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pair  <= n_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_start_col <= n_start_col;
        r_end_row   <= n_end_row;
        r_end_col   <= n_end_col;
        r_rgb       <= n_rgb;
    end

    assign o_waddr = (r_state == S_CLEAR) ? r_clr : fill_addr;
    assign o_wdata = (r_state == S_CLEAR) ? '0 : r_rgb;
    assign o_raddr = AW'(r_pair) * AW'(PANEL_COLUMNS) + AW'(r_col);
    assign o_tag.row_address  = ROW_ADDR_W'(r_pair);
    assign o_tag.column_index = COLUMN_W'(r_col);
    assign o_tag.latch_last   = scan_last;

    a_refresh_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_cmd.operation == OP_REFRESH) |=> r_state == S_SCAN)
        else $error("refresh did not start a scan");

    a_no_read_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.re && (o_ctl.we_top || o_ctl.we_bot)))
        else $error("read and write issued together");

    a_read_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.re |-> i_space)
        else $error("read issued without output space");
endmodule

### rtl/core/lmfs_out.sv
module lmfs_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_re,
    input  lmfs_pkg::t_scan_tag          i_tag,
    input  logic [lmfs_pkg::COLOR_W-1:0] i_top,
    input  logic [lmfs_pkg::COLOR_W-1:0] i_bot,
    output logic                         o_space,
    lmfs_pix_if.source                   o_pix
);
    import lmfs_pkg::*;

    logic        r_pend;
    t_scan_tag   r_tag;
    t_out_word   r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  occ;
    logic        pop;
    t_out_word   head;

    assign pop   = o_pix.valid && o_pix.ready;
    assign occ   = r_cnt + 2'(r_pend);
    assign o_space = (occ - 2'(pop)) < 2'd2;
    assign n_cnt = r_cnt + 2'(r_pend) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_pend <= i_re;
            r_cnt  <= n_cnt;
            if (r_pend) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_tag <= i_tag;
        end
        if (r_pend) begin
            r_q[r_wp] <= '{tag: r_tag, top: i_top, bot: i_bot};
        end
    end

    assign head = r_q[r_rp];

    assign o_pix.valid        = (r_cnt != '0);
    assign o_pix.row_address  = head.tag.row_address;
    assign o_pix.column_index = head.tag.column_index;
    assign o_pix.latch_last   = head.tag.latch_last;
    assign o_pix.top_red      = head.top[0];
    assign o_pix.top_green    = head.top[1];
    assign o_pix.top_blue     = head.top[2];
    assign o_pix.bottom_red   = head.bot[0];
    assign o_pix.bottom_green = head.bot[1];
    assign o_pix.bottom_blue  = head.bot[2];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (3'(r_cnt) + 3'(r_pend)) <= 3'd2)
        else $error("output queue overrun");

    a_valid_drops_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_pix.valid) |-> $past(o_pix.ready))
        else $error("word dropped without handshake");

    a_word_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |=> o_pix.valid && $stable(head))
        else $error("word changed while stalled");
endmodule

### dv/tb_led_matrix_framebuffer_scan.sv
`timescale 1ns / 100ps

module tb_led_matrix_framebuffer_scan;
    import lmfs_pkg::*;

    localparam int COLS          = DEF_PANEL_COLUMNS;
    localparam int ROWS          = DEF_PANEL_ROWS;
    localparam int HALF          = DEF_PANEL_ROWS / 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 600;
    localparam int WORDS_PER_PHASE = 34;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]        op;
        logic [START_ROW_W-1:0] row;
        logic [START_COL_W-1:0] col;
        logic [RECT_W_W-1:0]    wid;
        logic [RECT_H_W-1:0]    hgt;
        logic [COLOR_W-1:0]     rgb;
        bit                     drain_first;
    } t_cmd_word;

    logic i_clk;
    logic i_rst_n;

    lmfs_cmd_if cmd_if ();
    lmfs_pix_if pix_if ();

    led_matrix_framebuffer_scan u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    t_cmd_word       pending_words [$];
    t_out_word       scan_words_due [$];
    logic [COLOR_W-1:0] panel_bits [ROWS][COLS];
    logic [ROW_ADDR_W-1:0] scan_pair;

    int send_idle_pct;
    int sink_stall_pct;
    int fail_count;
    int cycle_count;

    always #6 i_clk = ~i_clk;

    function automatic void store_pixel(int row, int col, logic [COLOR_W-1:0] rgb);
        int dest;
        if (row >= ROWS || col >= COLS) return;
        dest = (row % HALF == 0) ? row + HALF - 1 : row - 1;
        panel_bits[dest][col] = rgb;
    endfunction

    function automatic void apply_command(t_cmd_word w);
        t_out_word exp_word;
        case (w.op)
            OP_PIXEL: begin
                store_pixel(int'(w.row), int'(w.col), w.rgb);
            end
            OP_FILL: begin
                for (int r = 0; r < int'(w.hgt); r++)
                    for (int c = 0; c < int'(w.wid); c++)
                        store_pixel(int'(w.row) + r, int'(w.col) + c, w.rgb);
            end
            OP_REFRESH: begin
                for (int c = 0; c < COLS; c++) begin
                    exp_word.tag.row_address  = scan_pair;
                    exp_word.tag.column_index = c[COLUMN_W-1:0];
                    exp_word.tag.latch_last   = (c == COLS - 1);
                    exp_word.top              = panel_bits[scan_pair][c];
                    exp_word.bot              = panel_bits[int'(scan_pair) + HALF][c];
                    scan_words_due.push_back(exp_word);
                end
                scan_pair = ROW_ADDR_W'((int'(scan_pair) + 1) % HALF);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_cmd(logic [OP_W-1:0] op, int row, int col, int wid,
                                     int hgt, int rgb, bit drain_first);
        t_cmd_word w;
        w.op          = op;
        w.row         = row[START_ROW_W-1:0];
        w.col         = col[START_COL_W-1:0];
        w.wid         = wid[RECT_W_W-1:0];
        w.hgt         = hgt[RECT_H_W-1:0];
        w.rgb         = rgb[COLOR_W-1:0];
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endfunction

    function automatic t_cmd_word random_command();
        t_cmd_word w;
        int        pick;
        pick          = $urandom_range(99);
        w.row         = START_ROW_W'($urandom_range(ROWS - 1));
        w.col         = START_COL_W'($urandom_range(COLS - 1));
        w.rgb         = COLOR_W'($urandom_range(7));
        w.wid         = RECT_W_W'($urandom_range(63));
        w.hgt         = RECT_H_W'($urandom_range(31));
        w.drain_first = 1'b0;
        if (pick < 35) begin
            w.op = OP_PIXEL;
        end else if (pick < 55) begin
            w.op = OP_FILL;
            if ($urandom_range(9) != 0) begin
                w.wid = RECT_W_W'($urandom_range(6));
                w.hgt = RECT_H_W'($urandom_range(3));
            end
        end else if (pick < 95) begin
            w.op = OP_REFRESH;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    // drive command words
    always @(posedge i_clk) begin : drive_cmd
        t_cmd_word nxt;
        logic      issue;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            issue = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                if (!pending_words[0].drain_first ||
                    (scan_words_due.size() == 0 && !(cmd_if.valid && cmd_if.ready)))
                    issue = 1'b1;
            end
            if (issue) begin
                nxt = pending_words.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.operation   <= nxt.op;
                cmd_if.start_row   <= nxt.row;
                cmd_if.start_col   <= nxt.col;
                cmd_if.rect_width  <= nxt.wid;
                cmd_if.rect_height <= nxt.hgt;
                cmd_if.color_red   <= nxt.rgb[0];
                cmd_if.color_green <= nxt.rgb[1];
                cmd_if.color_blue  <= nxt.rgb[2];
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        pix_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // check scan words, then predict from accepted commands
    always @(posedge i_clk) begin : watch
        t_cmd_word w;
        t_out_word act;
        t_out_word exp_word;
        if (i_rst_n) begin
            if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
                act.tag.row_address  = pix_if.row_address;
                act.tag.column_index = pix_if.column_index;
                act.tag.latch_last   = pix_if.latch_last;
                act.top = {pix_if.top_blue, pix_if.top_green, pix_if.top_red};
                act.bot = {pix_if.bottom_blue, pix_if.bottom_green, pix_if.bottom_red};
                if (scan_words_due.size() == 0) begin
                    $display("%0t: expected none, got row %0d col %0d top %b bot %b last %b",
                             $time, act.tag.row_address, act.tag.column_index,
                             act.top, act.bot, act.tag.latch_last);
                    fail_count++;
                end else begin
                    exp_word = scan_words_due.pop_front();
                    if (act.tag.row_address !== exp_word.tag.row_address ||
                        act.tag.column_index !== exp_word.tag.column_index ||
                        act.tag.latch_last !== exp_word.tag.latch_last ||
                        act.top !== exp_word.top || act.bot !== exp_word.bot) begin
                        $display("%0t: exp %0d/%0d %b %b %b, got %0d/%0d %b %b %b",
                                 $time, exp_word.tag.row_address,
                                 exp_word.tag.column_index, exp_word.top, exp_word.bot,
                                 exp_word.tag.latch_last, act.tag.row_address,
                                 act.tag.column_index, act.top, act.bot,
                                 act.tag.latch_last);
                        fail_count++;
                    end
                end
            end
            if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
                w.op  = cmd_if.operation;
                w.row = cmd_if.start_row;
                w.col = cmd_if.start_col;
                w.wid = cmd_if.rect_width;
                w.hgt = cmd_if.rect_height;
                w.rgb = {cmd_if.color_blue, cmd_if.color_green, cmd_if.color_red};
                apply_command(w);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d scan words outstanding", $time,
                     scan_words_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        t_cmd_word w;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.operation   = OP_PIXEL;
        cmd_if.start_row   = '0;
        cmd_if.start_col   = '0;
        cmd_if.rect_width  = '0;
        cmd_if.rect_height = '0;
        cmd_if.color_red   = 1'b0;
        cmd_if.color_green = 1'b0;
        cmd_if.color_blue  = 1'b0;
        pix_if.ready       = 1'b0;
        send_idle_pct      = 0;
        sink_stall_pct     = 0;
        fail_count         = 0;
        cycle_count        = 0;
        scan_pair          = '0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                panel_bits[r][c] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, row remap at both half boundaries, clipping, empty fills, unused op
        push_cmd(OP_REFRESH, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_PIXEL, 0, 0, 0, 0, 1, 0);
        push_cmd(OP_PIXEL, 15, 31, 63, 31, 7, 0);
        push_cmd(OP_PIXEL, 8, 0, 0, 0, 2, 0);
        push_cmd(OP_PIXEL, 7, 31, 0, 0, 4, 0);
        push_cmd(OP_PIXEL, 1, 16, 0, 0, 5, 0);
        push_cmd(OP_PIXEL, 9, 1, 0, 0, 3, 0);
        push_cmd(OP_FILL, 12, 28, 63, 31, 6, 0);
        push_cmd(OP_FILL, 3, 3, 0, 5, 7, 0);
        push_cmd(OP_FILL, 3, 3, 5, 0, 7, 0);
        push_cmd(OP_UNUSED, 2, 2, 1, 1, 7, 0);
        push_cmd(OP_REFRESH, 0, 0, 0, 0, 0, 1);
        for (int i = 0; i < 7; i++)
            push_cmd(OP_REFRESH, 15, 31, 63, 31, 7, 0);
        push_cmd(OP_FILL, 0, 0, 32, 16, 5, 0);
        push_cmd(OP_PIXEL, 4, 10, 0, 0, 0, 0);
        push_cmd(OP_REFRESH, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_FILL, 0, 0, 32, 16, 0, 1);
        push_cmd(OP_REFRESH, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin send_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                w = random_command();
                if (sent == WORDS_PER_PHASE / 2) w.drain_first = 1'b1;
                if (w.op != OP_UNUSED) sent++;
                pending_words.push_back(w);
            end
            while (pending_words.size() != 0) @(negedge i_clk);
        end

        while (pending_words.size() != 0 || cmd_if.valid) @(negedge i_clk);
        while (scan_words_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (scan_words_due.size() != 0) begin
            $display("%0t: %0d scan words never arrived", $time, scan_words_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
